// File: hdl/tmdps_pkg.sv
package tmdps_pkg;

  localparam int ElemW  = 16;
  localparam int IdxW   = 9;
  localparam int IdW    = 16;
  localparam int ProdW  = 32;
  localparam int AccW   = 48;
  localparam int ScoreW = 32;

  localparam logic signed [ScoreW-1:0] MinusOneQ130 = 32'shC000_0000;
  localparam logic signed [ScoreW-1:0] ScoreMax     = 32'sh7FFF_FFFF;
  localparam logic signed [ScoreW-1:0] ScoreMin     = 32'sh8000_0000;

  typedef enum logic {
    REQ_QUERY   = 1'b0,
    REQ_GALLERY = 1'b1
  } req_type_e;

  // Gallery item moving down the pipeline.
  typedef struct packed {
    logic                    valid;
    logic                    acc_en;
    logic                    end_vec;
    logic                    end_gal;
    logic [IdW-1:0]          id;
    logic signed [ElemW-1:0] value;
  } s1_t;

  typedef struct packed {
    logic                    valid;
    logic                    end_vec;
    logic                    end_gal;
    logic [IdW-1:0]          id;
    logic signed [ProdW-1:0] prod;
  } s2_t;

endpackage

// File: hdl/tmdps_ram.sv
module tmdps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/thresholded_max_dot_product_search.sv
// Path of the item ending the gallery to a valid result: query memory read at the edge that
// accepts it, then the product register, then the output register.
// Throughput: one item per cycle; input stalls only while a finished result is about to
// enter an output register that is still full and stalled.
// Reset (rst_ni, async, active low) clears the pipeline, the accumulator, the running best
// and the threshold; the query memory is not cleared and holds nothing until written.
module thresholded_max_dot_product_search #(
  parameter int VECTOR_DIM = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [8:0]  elem_index_i,
  input  logic signed [15:0] elem_value_i,
  input  logic [15:0] entry_id_i,
  input  logic        end_of_vector_i,
  input  logic        end_of_gallery_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] best_id_o,
  output logic        found_o,
  output logic signed [31:0] best_score_o
);

  localparam int AW = (VECTOR_DIM > 1) ? $clog2(VECTOR_DIM) : 1;
  localparam int PW = $clog2(VECTOR_DIM + 1);
  localparam int AccW = tmdps_pkg::AccW;
  localparam int ScoreW = tmdps_pkg::ScoreW;
  localparam int ProdW = tmdps_pkg::ProdW;

  logic hold;
  logic accept;
  logic is_gallery;
  logic q_we;
  logic [AW-1:0] q_waddr;
  logic [AW-1:0] q_raddr;
  logic signed [tmdps_pkg::ElemW-1:0] q_rdata;

  logic [PW-1:0] pos_q, pos_d;
  logic pos_live;

  tmdps_pkg::s1_t s1_q, s1_d;
  tmdps_pkg::s2_t s2_q, s2_d;

  logic signed [AccW-1:0]   acc_q, acc_d, acc_sum;
  logic signed [ScoreW-1:0] score_sat;
  logic signed [ScoreW-1:0] best_score_q, best_score_d;
  logic [tmdps_pkg::IdW-1:0] best_id_q, best_id_d;
  logic found_q, found_d;
  logic signed [ScoreW-1:0] thr_q;
  logic better;

  logic out_valid_q, out_valid_d;
  logic [tmdps_pkg::IdW-1:0] out_id_q, out_id_d;
  logic out_found_q, out_found_d;
  logic signed [ScoreW-1:0] out_score_q, out_score_d;

  // A gallery-end item in the product stage cannot move on while the output is full.
  assign hold = s2_q.valid && s2_q.end_gal && out_valid_q && out_stall_i;
  assign in_stall_o = hold;
  assign accept = in_valid_i && !hold;
  assign is_gallery = (req_type_i == tmdps_pkg::REQ_GALLERY);

  assign q_we = accept && !is_gallery && (32'(elem_index_i) < VECTOR_DIM);
  assign q_waddr = AW'(elem_index_i);
  assign q_raddr = pos_q[AW-1:0];
  assign pos_live = (pos_q < PW'(VECTOR_DIM));

  tmdps_ram #(
    .WIDTH(tmdps_pkg::ElemW),
    .DEPTH(VECTOR_DIM)
  ) u_query_ram (
    .clk_i  (clk_i),
    .we_i   (q_we),
    .waddr_i(q_waddr),
    .wdata_i(elem_value_i),
    .re_i   (accept && is_gallery),
    .raddr_i(q_raddr),
    .rdata_o(q_rdata)
  );

  // Element position and first pipeline stage.
  always_comb begin
    pos_d = pos_q;
    s1_d  = s1_q;
    if (!hold) begin
      s1_d.valid   = accept && is_gallery;
      s1_d.acc_en  = pos_live;
      s1_d.end_vec = end_of_vector_i;
      s1_d.end_gal = end_of_gallery_i;
      s1_d.id      = entry_id_i;
      s1_d.value   = elem_value_i;
      if (accept && is_gallery) begin
        if (end_of_vector_i || end_of_gallery_i) begin
          pos_d = '0;
        end else if (pos_live) begin
          pos_d = pos_q + PW'(1);
        end
      end
    end
  end

  // Product stage.
  always_comb begin
    s2_d = s2_q;
    if (!hold) begin
      s2_d.valid   = s1_q.valid;
      s2_d.end_vec = s1_q.end_vec;
      s2_d.end_gal = s1_q.end_gal;
      s2_d.id      = s1_q.id;
      s2_d.prod    = s1_q.acc_en ? ProdW'(s1_q.value * q_rdata) : '0;
    end
  end

  // Accumulate, saturate and compare against the running best and the threshold.
  always_comb begin
    acc_sum = acc_q + {{(AccW-ProdW){s2_q.prod[ProdW-1]}}, s2_q.prod};
    if (acc_sum[AccW-1:ScoreW-1] == '0 || acc_sum[AccW-1:ScoreW-1] == '1) begin
      score_sat = acc_sum[ScoreW-1:0];
    end else if (acc_sum[AccW-1]) begin
      score_sat = tmdps_pkg::ScoreMin;
    end else begin
      score_sat = tmdps_pkg::ScoreMax;
    end
    better = (score_sat > best_score_q) && (score_sat > thr_q);
  end

  always_comb begin
    acc_d        = acc_q;
    best_score_d = best_score_q;
    best_id_d    = best_id_q;
    found_d      = found_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_id_d     = out_id_q;
    out_found_d  = out_found_q;
    out_score_d  = out_score_q;
    if (!hold && s2_q.valid) begin
      acc_d = acc_sum;
      if (s2_q.end_vec || s2_q.end_gal) begin
        acc_d = '0;
        if (better) begin
          best_score_d = score_sat;
          best_id_d    = s2_q.id;
          found_d      = 1'b1;
        end
      end
      if (s2_q.end_gal) begin
        out_valid_d  = 1'b1;
        out_id_d     = best_id_d;
        out_found_d  = found_d;
        out_score_d  = best_score_d;
        best_score_d = tmdps_pkg::MinusOneQ130;
        best_id_d    = '0;
        found_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      s1_q         <= '0;
      s2_q         <= '0;
      acc_q        <= '0;
      best_score_q <= tmdps_pkg::MinusOneQ130;
      best_id_q    <= '0;
      found_q      <= 1'b0;
      thr_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      s1_q         <= s1_d;
      s2_q         <= s2_d;
      acc_q        <= acc_d;
      best_score_q <= best_score_d;
      best_id_q    <= best_id_d;
      found_q      <= found_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_id_q     <= out_id_d;
    out_found_q  <= out_found_d;
    out_score_q  <= out_score_d;
  end

  assign out_valid_o  = out_valid_q;
  assign best_id_o    = out_id_q;
  assign found_o      = out_found_q;
  assign best_score_o = out_score_q;

endmodule
